// ===== rtl/bmhq_pkg.sv =====
package bmhq_pkg;

    localparam int KEY_W = 16;
    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] LIMIT_RESET = 7'd64;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CFG_W-1:0] limit_t;

    typedef enum logic [0:0] {
        CMD_INSERT = 1'b0,
        CMD_REMOVE = 1'b1
    } cmd_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic insert;
        logic remove;
        key_t key;
    } cell_op_t;

endpackage

// ===== rtl/bmhq_req_if.sv =====
interface bmhq_req_if import bmhq_pkg::*; ();
    logic valid;
    logic ready;
    logic cmd;
    key_t value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

// ===== rtl/bmhq_rsp_if.sv =====
interface bmhq_rsp_if import bmhq_pkg::*; #(
    parameter int CNT_W = 7
) ();
    logic valid;
    logic ready;
    key_t min_value;
    logic was_empty;
    logic was_full;
    logic [CNT_W-1:0] count;

    modport source (output valid, output min_value, output was_empty, output was_full,
                    output count, input ready);
    modport sink (input valid, input min_value, input was_empty, input was_full,
                  input count, output ready);
endinterface

// ===== rtl/bmhq_cell.sv =====
module bmhq_cell import bmhq_pkg::*; (
    input  logic     clk,
    input  cell_op_t op,
    input  logic     occupied,
    input  logic     left_live,
    input  logic     left_take,
    input  key_t     left_key,
    input  key_t     right_key,
    output logic     take,
    output key_t     key
);

    key_t key_reg;
    key_t key_next;

    // an empty slot behaves as an infinitely large key
    assign take = !occupied || (op.key < key_reg);
    assign key  = key_reg;

    always_comb
    begin
        key_next = key_reg;
        priority if (op.insert)
        begin
            if (take)
            begin
                key_next = (left_live && left_take) ? left_key : op.key;
            end
        end
        else if (op.remove)
        begin
            key_next = right_key;
        end
        else
        begin
            // no request this cycle: hold
            key_next = key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

// ===== rtl/binary_min_heap_queue.sv =====
// Min priority queue: insert a key, or remove and return the smallest key.
// The response is registered: it appears in the cycle after the request is accepted.
// Throughput: one request per cycle while rsp.ready keeps the response draining; every
// cell of the sorted row shifts together, and a new request enters in the same cycle the pending response drains.
// Reset: element count cleared, capacity limit set to 64, output empty;
// the key cells are not reset and are read only while occupied.
module binary_min_heap_queue import bmhq_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int CNT_W    = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  limit_t             cfg_wdata,
    bmhq_req_if.sink           req,
    bmhq_rsp_if.source         rsp
);

    // compare width wide enough for both the count and the 7-bit limit
    localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [LIM_W-1:0] CAP_L = LIM_W'(CAPACITY);

    limit_t           limit_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    key_t             min_value_reg;
    logic             was_empty_reg;
    logic             was_full_reg;
    logic [CNT_W-1:0] out_count_reg;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [LIM_W-1:0] limit_eff;
    cell_op_t         op;
    key_t             min_value_next;
    logic             was_empty_next;
    logic             was_full_next;

    key_t             cell_key  [CAPACITY];
    logic             cell_take [CAPACITY];

    // take a new request whenever the output register is free or draining
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // clamp the limit to the physical capacity
    assign limit_eff = (LIM_W'(limit_reg) > CAP_L) ? CAP_L : LIM_W'(limit_reg);
    assign is_full   = LIM_W'(count_reg) >= limit_eff;
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        op             = '{insert: 1'b0, remove: 1'b0, key: req.value};
        count_next     = count_reg;
        min_value_next = '0;
        was_empty_next = 1'b0;
        was_full_next  = 1'b0;
        unique case (cmd_t'(req.cmd))
            CMD_INSERT:
            begin
                was_full_next = is_full;
                op.insert     = accept && !is_full;
                if (op.insert)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                was_empty_next = is_empty;
                op.remove      = accept && !is_empty;
                // the head cell holds the minimum
                min_value_next = is_empty ? '0 : cell_key[0];
                if (op.remove)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                op.insert = 1'b0;
            end
        endcase
    end

    // sorted row: cell 0 holds the smallest key, occupied cells are 0..count-1
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic left_live;
            logic left_take;
            key_t left_key;
            key_t right_key;

            if (g == 0)
            begin : g_head
                assign left_live = 1'b0;
                assign left_take = 1'b0;
                assign left_key  = op.key;
            end
            else
            begin : g_body
                assign left_live = 1'b1;
                assign left_take = cell_take[g-1];
                assign left_key  = cell_key[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_key = cell_key[g];
            end
            else
            begin : g_inner
                assign right_key = cell_key[g+1];
            end

            bmhq_cell u_cell (
                .clk       (clk),
                .op        (op),
                .occupied  (CNT_W'(g) < count_reg),
                .left_live (left_live),
                .left_take (left_take),
                .left_key  (left_key),
                .right_key (right_key),
                .take      (cell_take[g]),
                .key       (cell_key[g])
            );
        end
    endgenerate

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            min_value_reg <= min_value_next;
            was_empty_reg <= was_empty_next;
            was_full_reg  <= was_full_next;
            out_count_reg <= count_next;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.min_value = min_value_reg;
    assign rsp.was_empty = was_empty_reg;
    assign rsp.was_full  = was_full_reg;
    assign rsp.count     = out_count_reg;

endmodule
